[sv/crs_pkg.sv]
`default_nettype none
package crs_pkg;

  localparam int DATA_W    = 32;
  localparam int TOL_W     = 31;
  localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

  localparam int PROD_W    = 2 * DATA_W;
  localparam int COF_W     = PROD_W + 1;
  localparam int TERM_W    = DATA_W + COF_W;
  localparam int SUM_W     = TERM_W + 2;
  localparam int MAG_W     = SUM_W - 1;
  localparam int DIV_STEPS = DATA_W;

  localparam int N_COF  = 6;
  localparam int N_TERM = 12;
  localparam int N_SUM  = 4;
  localparam int N_LANE = 3;

  localparam logic [DATA_W-1:0] SOL_POS_LIM = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SOL_NEG_LIM = 32'h8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] m00;
    logic signed [DATA_W-1:0] m01;
    logic signed [DATA_W-1:0] m02;
    logic signed [DATA_W-1:0] m10;
    logic signed [DATA_W-1:0] m11;
    logic signed [DATA_W-1:0] m12;
    logic signed [DATA_W-1:0] m20;
    logic signed [DATA_W-1:0] m21;
    logic signed [DATA_W-1:0] m22;
    logic signed [DATA_W-1:0] rhs0;
    logic signed [DATA_W-1:0] rhs1;
    logic signed [DATA_W-1:0] rhs2;
  } crs_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sol0;
    logic signed [DATA_W-1:0] sol1;
    logic signed [DATA_W-1:0] sol2;
    logic                     solvable;
    logic                     saturated;
  } crs_out_t;

  // width of the scaled dividend and of the overflow threshold
  function automatic int num_width(input int frac);
    int wn;
    int wt;
    wn = MAG_W + frac + 2;
    wt = MAG_W + DIV_STEPS + 2;
    return (wn > wt) ? wn : wt;
  endfunction

endpackage
`default_nettype wire

[sv/crs_cofactor.sv]
`default_nettype none
module crs_cofactor import crs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  input  crs_in_t                  up_item,
  output logic                     up_rdy,
  output logic                     dn_valid,
  input  logic                     dn_rdy,
  output crs_in_t                  dn_item,
  output logic signed [COF_W-1:0]  dn_cof [N_COF]
);

  logic signed [DATA_W-1:0] fa [N_TERM];
  logic signed [DATA_W-1:0] fb [N_TERM];

  logic                     v1_r, v2_r;
  logic                     rdy1, rdy2;
  crs_in_t                  item1_r, item2_r;
  logic signed [PROD_W-1:0] prod1_r [N_TERM];
  logic signed [COF_W-1:0]  cof2_r [N_COF];

  // cofactors c0..c2 of column 0, then the rhs minors t0..t2
  always_comb begin
    fa[0]  = up_item.m11;  fb[0]  = up_item.m22;
    fa[1]  = up_item.m21;  fb[1]  = up_item.m12;
    fa[2]  = up_item.m02;  fb[2]  = up_item.m21;
    fa[3]  = up_item.m01;  fb[3]  = up_item.m22;
    fa[4]  = up_item.m01;  fb[4]  = up_item.m12;
    fa[5]  = up_item.m02;  fb[5]  = up_item.m11;
    fa[6]  = up_item.m00;  fb[6]  = up_item.rhs1;
    fa[7]  = up_item.rhs0; fb[7]  = up_item.m10;
    fa[8]  = up_item.rhs0; fb[8]  = up_item.m20;
    fa[9]  = up_item.m00;  fb[9]  = up_item.rhs2;
    fa[10] = up_item.m10;  fb[10] = up_item.rhs2;
    fa[11] = up_item.rhs1; fb[11] = up_item.m20;
  end

  assign rdy2   = !v2_r || dn_rdy;
  assign rdy1   = !v1_r || rdy2;
  assign up_rdy = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      item1_r <= up_item;
      for (int j = 0; j < N_TERM; j++) begin
        prod1_r[j] <= fa[j] * fb[j];
      end
    end
    if (rdy2) begin
      item2_r <= item1_r;
      for (int k = 0; k < N_COF; k++) begin
        cof2_r[k] <= COF_W'(prod1_r[2*k]) - COF_W'(prod1_r[2*k+1]);
      end
    end
  end

  assign dn_valid = v2_r;
  assign dn_item  = item2_r;
  assign dn_cof   = cof2_r;

endmodule
`default_nettype wire

[sv/crs_dot.sv]
`default_nettype none
module crs_dot import crs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  input  crs_in_t                  up_item,
  input  logic signed [COF_W-1:0]  up_cof [N_COF],
  output logic                     up_rdy,
  output logic                     dn_valid,
  input  logic                     dn_rdy,
  output logic signed [SUM_W-1:0]  dn_sum [N_SUM]
);

  logic signed [DATA_W-1:0] sc [N_TERM];
  logic signed [COF_W-1:0]  ca [N_TERM];

  logic                     v1_r, v2_r, v3_r;
  logic                     rdy1, rdy2, rdy3;
  logic signed [COF_W-1:0]  pp_lo_r [N_TERM];
  logic signed [COF_W-1:0]  pp_hi_r [N_TERM];
  logic signed [TERM_W-1:0] term_r [N_TERM];
  logic signed [SUM_W-1:0]  sum_r [N_SUM];

  // terms grouped by three: det, x numerator, y numerator, negated z numerator
  always_comb begin
    sc[0]  = up_item.m00;  ca[0]  = up_cof[0];
    sc[1]  = up_item.m10;  ca[1]  = up_cof[1];
    sc[2]  = up_item.m20;  ca[2]  = up_cof[2];
    sc[3]  = up_item.rhs0; ca[3]  = up_cof[0];
    sc[4]  = up_item.rhs1; ca[4]  = up_cof[1];
    sc[5]  = up_item.rhs2; ca[5]  = up_cof[2];
    sc[6]  = up_item.m22;  ca[6]  = up_cof[3];
    sc[7]  = up_item.m12;  ca[7]  = up_cof[4];
    sc[8]  = up_item.m02;  ca[8]  = up_cof[5];
    sc[9]  = up_item.m21;  ca[9]  = up_cof[3];
    sc[10] = up_item.m11;  ca[10] = up_cof[4];
    sc[11] = up_item.m01;  ca[11] = up_cof[5];
  end

  assign rdy3   = !v3_r || dn_rdy;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign up_rdy = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      // 32 x 65 split into two partial products of about 32 x 32
      for (int k = 0; k < N_TERM; k++) begin
        pp_lo_r[k] <= sc[k] * $signed({1'b0, ca[k][DATA_W-1:0]});
        pp_hi_r[k] <= sc[k] * $signed(ca[k][COF_W-1:DATA_W]);
      end
    end
    if (rdy2) begin
      for (int k = 0; k < N_TERM; k++) begin
        term_r[k] <= $signed({pp_hi_r[k], {DATA_W{1'b0}}}) + TERM_W'(pp_lo_r[k]);
      end
    end
    if (rdy3) begin
      for (int s = 0; s < N_SUM; s++) begin
        sum_r[s] <= SUM_W'(term_r[3*s]) + SUM_W'(term_r[3*s+1]) + SUM_W'(term_r[3*s+2]);
      end
    end
  end

  assign dn_valid = v3_r;
  assign dn_sum   = sum_r;

endmodule
`default_nettype wire

[sv/crs_prep.sv]
`default_nettype none
module crs_prep import crs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  input  logic signed [SUM_W-1:0]  up_sum [N_SUM],
  input  logic [TOL_W-1:0]         tol,
  output logic                     up_rdy,
  output logic                     dn_valid,
  input  logic                     dn_rdy,
  output logic [num_width(FRAC_BITS)-1:0] dn_num [N_LANE],
  output logic [num_width(FRAC_BITS)-1:0] dn_div,
  output logic [N_LANE-1:0]        dn_neg,
  output logic [N_LANE-1:0]        dn_sat,
  output logic                     dn_ok
);

  localparam int W_X  = num_width(FRAC_BITS);
  localparam int RD_W = MAG_W + 1;
  localparam logic [RD_W-1:0] HALF = {{(RD_W-1){1'b0}}, 1'b1} << (2*FRAC_BITS-1);

  logic                 v1_r, v2_r, v3_r;
  logic                 rdy1, rdy2, rdy3;

  logic [MAG_W-1:0]     dmag1_r;
  logic                 dzero1_r;
  logic [MAG_W-1:0]     nmag1_r [N_LANE];
  logic [N_LANE-1:0]    neg1_r, neg2_r, neg3_r;

  logic [W_X-1:0]       n2_2_r [N_LANE];
  logic [W_X-1:0]       thr2_r [N_LANE];
  logic [W_X-1:0]       div2_r, div3_r;
  logic                 ok2_r, ok3_r;

  logic [W_X-1:0]       n2_3_r [N_LANE];
  logic [N_LANE-1:0]    sat3_r;

  logic [RD_W-1:0]      rd_sum;

  assign rdy3   = !v3_r || dn_rdy;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign up_rdy = rdy1;

  // determinant rounded to nearest, ties away from zero
  assign rd_sum = (RD_W'(dmag1_r) + HALF) >> (2*FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dmag1_r  <= MAG_W'(up_sum[0][SUM_W-1] ? -up_sum[0] : up_sum[0]);
      dzero1_r <= (up_sum[0] == '0);
      for (int l = 0; l < N_LANE; l++) begin
        nmag1_r[l] <= MAG_W'(up_sum[l+1][SUM_W-1] ? -up_sum[l+1] : up_sum[l+1]);
      end
      neg1_r[0] <= up_sum[1][SUM_W-1] ^ up_sum[0][SUM_W-1];
      neg1_r[1] <= up_sum[2][SUM_W-1] ^ up_sum[0][SUM_W-1];
      // z numerator arrives negated; a zero numerator gives zero either way
      neg1_r[2] <= !up_sum[3][SUM_W-1] ^ up_sum[0][SUM_W-1];
    end
    if (rdy2) begin
      div2_r <= W_X'(dmag1_r) << 1;
      ok2_r  <= !dzero1_r && !(rd_sum < RD_W'(tol));
      neg2_r <= neg1_r;
      for (int l = 0; l < N_LANE; l++) begin
        n2_2_r[l] <= (W_X'(nmag1_r[l]) << (FRAC_BITS + 1)) + W_X'(dmag1_r);
        // (limit + 1) times the doubled divisor
        thr2_r[l] <= (W_X'(dmag1_r) << DIV_STEPS)
                   + (neg1_r[l] ? (W_X'(dmag1_r) << 1) : '0);
      end
    end
    if (rdy3) begin
      div3_r <= div2_r;
      ok3_r  <= ok2_r;
      neg3_r <= neg2_r;
      for (int l = 0; l < N_LANE; l++) begin
        n2_3_r[l] <= n2_2_r[l];
        sat3_r[l] <= (n2_2_r[l] >= thr2_r[l]);
      end
    end
  end

  assign dn_valid = v3_r;
  assign dn_num   = n2_3_r;
  assign dn_div   = div3_r;
  assign dn_neg   = neg3_r;
  assign dn_sat   = sat3_r;
  assign dn_ok    = ok3_r;

endmodule
`default_nettype wire

[sv/crs_div.sv]
`default_nettype none
module crs_div import crs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  input  logic [num_width(FRAC_BITS)-1:0] up_num [N_LANE],
  input  logic [num_width(FRAC_BITS)-1:0] up_div,
  input  logic [N_LANE-1:0]        up_neg,
  input  logic [N_LANE-1:0]        up_sat,
  input  logic                     up_ok,
  output logic                     up_rdy,
  output logic                     dn_valid,
  input  logic                     dn_rdy,
  output logic [DATA_W-1:0]        dn_q [N_LANE],
  output logic [N_LANE-1:0]        dn_neg,
  output logic [N_LANE-1:0]        dn_sat,
  output logic                     dn_ok
);

  localparam int W_X = num_width(FRAC_BITS);

  logic                 v_r    [DIV_STEPS];
  logic [W_X-1:0]       rem_r  [DIV_STEPS][N_LANE];
  logic [DATA_W-1:0]    q_r    [DIV_STEPS][N_LANE];
  logic [W_X-1:0]       div_r  [DIV_STEPS];
  logic [N_LANE-1:0]    neg_r  [DIV_STEPS];
  logic [N_LANE-1:0]    sat_r  [DIV_STEPS];
  logic                 ok_r   [DIV_STEPS];

  logic                 v_in   [DIV_STEPS];
  logic [W_X-1:0]       rem_in [DIV_STEPS][N_LANE];
  logic [DATA_W-1:0]    q_in   [DIV_STEPS][N_LANE];
  logic [W_X-1:0]       div_in [DIV_STEPS];
  logic [N_LANE-1:0]    neg_in [DIV_STEPS];
  logic [N_LANE-1:0]    sat_in [DIV_STEPS];
  logic                 ok_in  [DIV_STEPS];

  logic [W_X-1:0]       rem_nxt [DIV_STEPS][N_LANE];
  logic [DATA_W-1:0]    q_nxt   [DIV_STEPS][N_LANE];
  logic [W_X-1:0]       shifted [DIV_STEPS];
  logic [DIV_STEPS:0]   rdy;

  always_comb begin
    rdy[DIV_STEPS] = dn_rdy;
    for (int s = DIV_STEPS - 1; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  // one restoring step per stage, quotient bit DIV_STEPS-1-s at stage s
  always_comb begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (s == 0) begin
        v_in[s]   = up_valid;
        div_in[s] = up_div;
        neg_in[s] = up_neg;
        sat_in[s] = up_sat;
        ok_in[s]  = up_ok;
        for (int l = 0; l < N_LANE; l++) begin
          rem_in[s][l] = up_num[l];
          q_in[s][l]   = '0;
        end
      end else begin
        v_in[s]   = v_r[s-1];
        div_in[s] = div_r[s-1];
        neg_in[s] = neg_r[s-1];
        sat_in[s] = sat_r[s-1];
        ok_in[s]  = ok_r[s-1];
        for (int l = 0; l < N_LANE; l++) begin
          rem_in[s][l] = rem_r[s-1][l];
          q_in[s][l]   = q_r[s-1][l];
        end
      end
      shifted[s] = div_in[s] << (DIV_STEPS - 1 - s);
      for (int l = 0; l < N_LANE; l++) begin
        if (rem_in[s][l] >= shifted[s]) begin
          rem_nxt[s][l] = rem_in[s][l] - shifted[s];
          q_nxt[s][l]   = q_in[s][l] | (DATA_W'(1) << (DIV_STEPS - 1 - s));
        end else begin
          rem_nxt[s][l] = rem_in[s][l];
          q_nxt[s][l]   = q_in[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STEPS; s++) v_r[s] <= 1'b0;
    end else begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        if (rdy[s]) v_r[s] <= v_in[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (rdy[s]) begin
        div_r[s] <= div_in[s];
        neg_r[s] <= neg_in[s];
        sat_r[s] <= sat_in[s];
        ok_r[s]  <= ok_in[s];
        for (int l = 0; l < N_LANE; l++) begin
          rem_r[s][l] <= rem_nxt[s][l];
          q_r[s][l]   <= q_nxt[s][l];
        end
      end
    end
  end

  assign up_rdy   = rdy[0];
  assign dn_valid = v_r[DIV_STEPS-1];
  assign dn_q     = q_r[DIV_STEPS-1];
  assign dn_neg   = neg_r[DIV_STEPS-1];
  assign dn_sat   = sat_r[DIV_STEPS-1];
  assign dn_ok    = ok_r[DIV_STEPS-1];

endmodule
`default_nettype wire

[sv/cramer_solve_3x3.sv]
// 3x3 linear solver by Cramer's rule in signed fixed point (Q16.16 by default).
// Takes one item per cycle while the output is not stalled; each item passes through
// these stages in order: 2 stages form the 2x2 minors, 3 stages the
// 32x65 products and the determinant and numerator sums, 3 stages round the
// determinant and prepare the dividends, 32 stages of restoring division give
// one quotient bit each for all three components, and one output register.
// A determinant whose rounded magnitude is below cfg_wdata as last written
// (66 after reset), or that is exactly zero, gives solvable low and zero
// components. Quotients round to nearest with ties away from zero and clamp to
// the 32-bit range with saturated set. Each stage holds while the stage after
// it is full and stalled, so bubbles close up under output stall.
`default_nettype none
module cramer_solve_3x3 import crs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  crs_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output crs_out_t         out_data,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata
);

  localparam int W_X = num_width(FRAC_BITS);

  logic [TOL_W-1:0]         tol_r;

  logic                     cf_rdy, cf_valid;
  crs_in_t                  cf_item;
  logic signed [COF_W-1:0]  cf_cof [N_COF];

  logic                     dt_rdy, dt_valid;
  logic signed [SUM_W-1:0]  dt_sum [N_SUM];

  logic                     pr_rdy, pr_valid;
  logic [W_X-1:0]           pr_num [N_LANE];
  logic [W_X-1:0]           pr_div;
  logic [N_LANE-1:0]        pr_neg, pr_sat;
  logic                     pr_ok;

  logic                     dv_valid;
  logic [DATA_W-1:0]        dv_q [N_LANE];
  logic [N_LANE-1:0]        dv_neg, dv_sat;
  logic                     dv_ok;

  logic                     out_rdy;
  logic                     out_valid_r;
  crs_out_t                 out_data_r;
  crs_out_t                 res_nxt;
  logic [DATA_W-1:0]        mag [N_LANE];
  logic [DATA_W-1:0]        sol [N_LANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  crs_cofactor u_cof (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_item  (in_data),
    .up_rdy   (cf_rdy),
    .dn_valid (cf_valid),
    .dn_rdy   (dt_rdy),
    .dn_item  (cf_item),
    .dn_cof   (cf_cof)
  );

  crs_dot u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cf_valid),
    .up_item  (cf_item),
    .up_cof   (cf_cof),
    .up_rdy   (dt_rdy),
    .dn_valid (dt_valid),
    .dn_rdy   (pr_rdy),
    .dn_sum   (dt_sum)
  );

  logic dv_rdy;

  crs_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dt_valid),
    .up_sum   (dt_sum),
    .tol      (tol_r),
    .up_rdy   (pr_rdy),
    .dn_valid (pr_valid),
    .dn_rdy   (dv_rdy),
    .dn_num   (pr_num),
    .dn_div   (pr_div),
    .dn_neg   (pr_neg),
    .dn_sat   (pr_sat),
    .dn_ok    (pr_ok)
  );

  crs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (pr_valid),
    .up_num   (pr_num),
    .up_div   (pr_div),
    .up_neg   (pr_neg),
    .up_sat   (pr_sat),
    .up_ok    (pr_ok),
    .up_rdy   (dv_rdy),
    .dn_valid (dv_valid),
    .dn_rdy   (out_rdy),
    .dn_q     (dv_q),
    .dn_neg   (dv_neg),
    .dn_sat   (dv_sat),
    .dn_ok    (dv_ok)
  );

  always_comb begin
    for (int l = 0; l < N_LANE; l++) begin
      if (dv_sat[l]) begin
        mag[l] = dv_neg[l] ? SOL_NEG_LIM : SOL_POS_LIM;
      end else begin
        mag[l] = dv_q[l];
      end
      if (!dv_ok) begin
        sol[l] = '0;
      end else begin
        sol[l] = dv_neg[l] ? (DATA_W'(0) - mag[l]) : mag[l];
      end
    end
    res_nxt.sol0      = sol[0];
    res_nxt.sol1      = sol[1];
    res_nxt.sol2      = sol[2];
    res_nxt.solvable  = dv_ok;
    res_nxt.saturated = dv_ok && (|dv_sat);
  end

  assign out_rdy = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) out_data_r <= res_nxt;
  end

  assign in_stall  = !cf_rdy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an empty output register means every stage can move
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled with the output register empty");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.solvable |->
      (out_data_r.sol0 == '0 && out_data_r.sol1 == '0 && out_data_r.sol2 == '0
       && !out_data_r.saturated))
    else $error("singular item with nonzero result");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.saturated |->
      (out_data_r.sol0 == SOL_POS_LIM || out_data_r.sol0 == SOL_NEG_LIM ||
       out_data_r.sol1 == SOL_POS_LIM || out_data_r.sol1 == SOL_NEG_LIM ||
       out_data_r.sol2 == SOL_POS_LIM || out_data_r.sol2 == SOL_NEG_LIM))
    else $error("saturated flag without a clamped component");

endmodule
`default_nettype wire
